// ===== rtl/core/fpba_pkg.sv =====
// Package for the fit-policy block allocator.
// Field widths, policy and command codes, register indexes and the sequencer state type.
// No dependencies.
package fpba_pkg;

  // Field widths of the request and result channels
  localparam int MODE_W      = 1;
  localparam int IDX_FIELD_W = 4;
  localparam int CAP_W       = 16;

  // Configuration port
  localparam int POLICY_W    = 3;
  localparam int NUMBLK_W    = 5;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_ADDR_W-1:0] CFG_POLICY     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_BLOCKS = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_RST = 3'd0;
  localparam logic [NUMBLK_W-1:0] NUMBLK_RST = 5'd16;

  // Placement policies; unused codes behave as first fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 3'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 3'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 3'd2;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 3'd3;
  localparam logic [POLICY_W-1:0] POL_LAST  = 3'd4;

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_LOAD  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } fsm_state_t;

endpackage

// ===== rtl/core/fpba_in_if.sv =====
// Request channel of the fit-policy block allocator: valid/ready plus request fields.
// Depends on fpba_pkg.
interface fpba_in_if import fpba_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [IDX_FIELD_W-1:0] block_index;
  logic [CAP_W-1:0]       block_capacity;
  logic [CAP_W-1:0]       request_size;

  modport source (output valid, mode, block_index, block_capacity, request_size,
                  input ready);
  modport sink   (input valid, mode, block_index, block_capacity, request_size,
                  output ready);
endinterface

// ===== rtl/core/fpba_out_if.sv =====
// Result channel of the fit-policy block allocator: valid/ready plus result fields.
// Depends on fpba_pkg.
interface fpba_out_if import fpba_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   granted;
  logic [IDX_FIELD_W-1:0] chosen_block;
  logic [CAP_W-1:0]       remaining_after;

  modport source (output valid, granted, chosen_block, remaining_after, input ready);
  modport sink   (input valid, granted, chosen_block, remaining_after, output ready);
endinterface

// ===== rtl/core/fit_policy_block_allocator_core.sv =====
// Fit-policy block allocator top level: config registers, scan sequencer, result register.
// Depends on fpba_pkg, fpba_in_if, fpba_out_if and fpba_table.
//
//  channel   dir  handshake              contents
//  in_req    in   valid/ready            mode, block_index, block_capacity, request_size
//  out_res   out  valid/ready            granted, chosen_block, remaining_after
//  cfg_*     in   cfg_we (no wait)       cfg_addr selects policy / num_blocks, cfg_wdata
//
// Load: the table is written on accept, then the result register is loaded.
// Allocate: the single table read port is walked one entry per cycle over the blocks in use
// (up to MAX_BLOCKS), followed by one compare drain and one write-back.
// One request is in flight at a time; the next is taken once the previous result is loaded.
// Reset (rst_n low, synchronous) clears the table to zero through valid bits at once.
// A stalled result holds in the output register; the sequencer waits in ST_FIN for it.
module fit_policy_block_allocator_core import fpba_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fpba_in_if.sink               in_req,
  fpba_out_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  // configuration registers
  logic [POLICY_W-1:0] policy_r;
  logic [NUMBLK_W-1:0] num_blocks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POLICY_RST;
      num_blocks_r <= NUMBLK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_POLICY:     policy_r     <= cfg_wdata[POLICY_W-1:0];
        CFG_NUM_BLOCKS: num_blocks_r <= cfg_wdata[NUMBLK_W-1:0];
        default: ;
      endcase
    end
  end

  // blocks in use, saturated at MAX_BLOCKS
  logic [CNT_W-1:0] nb_eff;
  always_comb begin
    if ({{(32-NUMBLK_W){1'b0}}, num_blocks_r} > 32'(MAX_BLOCKS)) begin
      nb_eff = CNT_W'(MAX_BLOCKS);
    end else begin
      nb_eff = CNT_W'(num_blocks_r);
    end
  end

  // sequencer and datapath registers
  fsm_state_t             st_r, st_nxt;
  logic [IDX_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]       scan_end_r, scan_end_nxt;
  logic                   desc_r, desc_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       pick_r, pick_nxt;
  logic [SIZE_BITS-1:0]   best_val_r, best_val_nxt;
  logic [SIZE_BITS-1:0]   req_r, req_nxt;
  logic                   is_alloc_r, is_alloc_nxt;
  logic [IDX_FIELD_W-1:0] ld_chosen_r, ld_chosen_nxt;
  logic [CAP_W-1:0]       ld_remain_r, ld_remain_nxt;
  logic [CNT_W-1:0]       rover_r, rover_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_granted_r, out_granted_nxt;
  logic [IDX_FIELD_W-1:0] out_chosen_r, out_chosen_nxt;
  logic [CAP_W-1:0]       out_remain_r, out_remain_nxt;

  // table ports
  logic                 tbl_wr_en;
  logic [IDX_W-1:0]     tbl_wr_addr;
  logic [SIZE_BITS-1:0] tbl_wr_data;
  logic [SIZE_BITS-1:0] tbl_rd_data;

  fpba_table #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (scan_idx_r),
    .rd_data (tbl_rd_data)
  );

  // compare stage: does the entry read last cycle beat the current pick
  logic fits, better, upd;
  always_comb begin
    fits = (tbl_rd_data >= req_r);
    case (policy_r)
      POL_BEST, POL_LAST: better = (tbl_rd_data < best_val_r);
      POL_WORST:          better = (tbl_rd_data > best_val_r);
      default:            better = 1'b0;
    endcase
    upd = cmp_vld_r && fits && (!found_r || better);
  end

  logic in_acc, push;
  logic [SIZE_BITS-1:0] cap_m, req_m, new_val;
  logic [CNT_W-1:0]     scan_start;

  assign in_req.ready = (st_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign push         = (st_r == ST_FIN) && (!out_valid_r || out_res.ready);
  assign cap_m        = SIZE_BITS'(in_req.block_capacity);
  assign req_m        = SIZE_BITS'(in_req.request_size);
  assign new_val      = best_val_r - req_r;
  assign scan_start   = (policy_r == POL_NEXT) ? rover_r : '0;

  // next state, table writes and result
  always_comb begin
    st_nxt          = st_r;
    scan_idx_nxt    = scan_idx_r;
    scan_end_nxt    = scan_end_r;
    desc_nxt        = desc_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    best_val_nxt    = best_val_r;
    req_nxt         = req_r;
    is_alloc_nxt    = is_alloc_r;
    ld_chosen_nxt   = ld_chosen_r;
    ld_remain_nxt   = ld_remain_r;
    rover_nxt       = rover_r;
    out_valid_nxt   = out_valid_r && !out_res.ready;
    out_granted_nxt = out_granted_r;
    out_chosen_nxt  = out_chosen_r;
    out_remain_nxt  = out_remain_r;
    tbl_wr_en       = 1'b0;
    tbl_wr_addr     = pick_r;
    tbl_wr_data     = new_val;

    if (upd) begin
      found_nxt    = 1'b1;
      pick_nxt     = cmp_idx_r;
      best_val_nxt = tbl_rd_data;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          found_nxt = 1'b0;
          req_nxt   = req_m;
          if (in_req.mode == MODE_LOAD) begin
            is_alloc_nxt  = 1'b0;
            ld_chosen_nxt = in_req.block_index;
            ld_remain_nxt = '0;
            if ({{(32-IDX_FIELD_W){1'b0}}, in_req.block_index} < 32'(MAX_BLOCKS)) begin
              tbl_wr_en     = 1'b1;
              tbl_wr_addr   = IDX_W'(in_req.block_index);
              tbl_wr_data   = cap_m;
              ld_remain_nxt = CAP_W'(cap_m);
            end
            st_nxt = ST_FIN;
          end else begin
            is_alloc_nxt = 1'b1;
            if (policy_r == POL_LAST) begin
              desc_nxt     = 1'b1;
              scan_idx_nxt = IDX_W'(nb_eff - CNT_W'(1));
              scan_end_nxt = '0;
              st_nxt       = (nb_eff == '0) ? ST_FIN : ST_SCAN;
            end else begin
              desc_nxt     = 1'b0;
              scan_idx_nxt = IDX_W'(scan_start);
              scan_end_nxt = IDX_W'(nb_eff - CNT_W'(1));
              st_nxt       = (scan_start >= nb_eff) ? ST_FIN : ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        // read issued at scan_idx_r, compared next cycle
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = scan_idx_r;
        if (scan_idx_r == scan_end_r) begin
          st_nxt = ST_DRAIN;
        end else if (desc_r) begin
          scan_idx_nxt = scan_idx_r - IDX_W'(1);
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (push) begin
          out_valid_nxt = 1'b1;
          if (!is_alloc_r) begin
            out_granted_nxt = 1'b0;
            out_chosen_nxt  = ld_chosen_r;
            out_remain_nxt  = ld_remain_r;
          end else if (found_r) begin
            tbl_wr_en       = 1'b1;
            out_granted_nxt = 1'b1;
            out_chosen_nxt  = IDX_FIELD_W'(pick_r);
            out_remain_nxt  = CAP_W'(new_val);
            if (policy_r == POL_NEXT) begin
              rover_nxt = CNT_W'(pick_r) + CNT_W'(1);
            end
          end else begin
            out_granted_nxt = 1'b0;
            out_chosen_nxt  = '0;
            out_remain_nxt  = '0;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      rover_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      rover_r     <= rover_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx_r    <= scan_idx_nxt;
    scan_end_r    <= scan_end_nxt;
    desc_r        <= desc_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    pick_r        <= pick_nxt;
    best_val_r    <= best_val_nxt;
    req_r         <= req_nxt;
    is_alloc_r    <= is_alloc_nxt;
    ld_chosen_r   <= ld_chosen_nxt;
    ld_remain_r   <= ld_remain_nxt;
    out_granted_r <= out_granted_nxt;
    out_chosen_r  <= out_chosen_nxt;
    out_remain_r  <= out_remain_nxt;
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.granted         = out_granted_r;
  assign out_res.chosen_block    = out_chosen_r;
  assign out_res.remaining_after = out_remain_r;

  // scan pointer stays inside the blocks in use
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (CNT_W'(scan_idx_r) < nb_eff))
    else $error("scan index beyond blocks in use");

  // a held pick always covers the request
  a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (best_val_r >= req_r))
    else $error("picked block smaller than request");

  // compare stage only live while the table is being walked
  a_cmp_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (st_r == ST_SCAN || st_r == ST_DRAIN))
    else $error("compare outside scan");

  // no new request while a table write-back is pending
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN) |-> !in_req.ready)
    else $error("request accepted during write-back");

  // rover never moves past the end of the table
  a_rover_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rover_r != $past(rover_r)) |-> (rover_r <= CNT_W'(MAX_BLOCKS)))
    else $error("rover out of range");

endmodule

// ===== rtl/core/fpba_table.sv =====
// Capacity table: synchronous single-write, single-read memory with registered read data.
// Per-entry valid bits make unwritten entries read as zero right after reset.
module fpba_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] mem_q_r;
  logic             vq_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  // valid bits: entry holds its reset value (zero) until first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vq_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vq_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = vq_r ? mem_q_r : '0;

endmodule

// ===== tb/sv/fit_policy_block_allocator_core_checker.sv =====
// Scoreboard for the fit-policy block allocator: tracks the capacity table, rover and
// registers, predicts each placement result and compares it. Depends on fpba_pkg.
module fit_policy_block_allocator_core_checker import fpba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [MODE_W-1:0]      in_mode,
  input  logic [IDX_FIELD_W-1:0] in_block_index,
  input  logic [CAP_W-1:0]       in_block_capacity,
  input  logic [CAP_W-1:0]       in_request_size,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_granted,
  input  logic [IDX_FIELD_W-1:0] out_chosen_block,
  input  logic [CAP_W-1:0]       out_remaining_after,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     pending
);

  localparam int NUM_SLOTS = 16;

  typedef struct packed {
    logic                   granted;
    logic [IDX_FIELD_W-1:0] chosen;
    logic [CAP_W-1:0]       remain;
  } placement_t;

  // Shadow copy of the allocator state and registers
  logic [CAP_W-1:0]    capacity_left [NUM_SLOTS];
  logic [4:0]          rover;
  logic [POLICY_W-1:0] policy;
  logic [NUMBLK_W-1:0] num_blocks;

  placement_t expected_placements[$];

  // One line per mismatch, counted
  task automatic report_mismatch(input string what, input logic [CAP_W-1:0] got,
                                 input logic [CAP_W-1:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one request to the shadow state and return the result it should produce
  function automatic placement_t place_request(input logic [MODE_W-1:0] mode,
                                               input logic [IDX_FIELD_W-1:0] idx,
                                               input logic [CAP_W-1:0] cap,
                                               input logic [CAP_W-1:0] req);
    placement_t res;
    int span;
    int pick;
    res = '0;
    if (mode == MODE_LOAD) begin
      capacity_left[idx] = cap;
      res.chosen = idx;
      res.remain = cap;
    end else begin
      span = (num_blocks > NUM_SLOTS) ? NUM_SLOTS : int'(num_blocks);
      pick = -1;
      case (policy)
        POL_BEST: begin
          for (int j = 0; j < span; j++)
            if (capacity_left[j] >= req && (pick < 0 || capacity_left[j] < capacity_left[pick]))
              pick = j;
        end
        POL_WORST: begin
          for (int j = 0; j < span; j++)
            if (capacity_left[j] >= req && (pick < 0 || capacity_left[j] > capacity_left[pick]))
              pick = j;
        end
        POL_NEXT: begin
          // scan from the rover, never wrapping
          for (int j = int'(rover); j < span; j++)
            if (pick < 0 && capacity_left[j] >= req)
              pick = j;
        end
        POL_LAST: begin
          // best fit scanned downward: highest index wins ties
          for (int j = span - 1; j >= 0; j--)
            if (capacity_left[j] >= req && (pick < 0 || capacity_left[j] < capacity_left[pick]))
              pick = j;
        end
        default: begin
          for (int j = 0; j < span; j++)
            if (pick < 0 && capacity_left[j] >= req)
              pick = j;
        end
      endcase
      if (pick >= 0) begin
        capacity_left[pick] = capacity_left[pick] - req;
        if (policy == POL_NEXT)
          rover = 5'(pick + 1);
        res.granted = 1'b1;
        res.chosen  = pick[IDX_FIELD_W-1:0];
        res.remain  = capacity_left[pick];
      end
    end
    return res;
  endfunction

  // Track registers and requests, check results in order
  always @(posedge clk) begin
    placement_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++)
        capacity_left[i] = '0;
      rover      = '0;
      policy     = POLICY_RST;
      num_blocks = NUMBLK_RST;
      expected_placements.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_POLICY)
          policy = cfg_wdata[POLICY_W-1:0];
        else if (cfg_addr == CFG_NUM_BLOCKS)
          num_blocks = cfg_wdata[NUMBLK_W-1:0];
      end
      if (in_valid && in_ready)
        expected_placements.push_back(place_request(in_mode, in_block_index,
                                                    in_block_capacity, in_request_size));
      if (out_valid && out_ready) begin
        if (expected_placements.size() == 0) begin
          report_mismatch("unexpected result, chosen_block", CAP_W'(out_chosen_block), '0);
        end else begin
          want = expected_placements.pop_front();
          if (out_granted !== want.granted)
            report_mismatch("granted", CAP_W'(out_granted), CAP_W'(want.granted));
          if (out_chosen_block !== want.chosen)
            report_mismatch("chosen_block", CAP_W'(out_chosen_block), CAP_W'(want.chosen));
          if (out_remaining_after !== want.remain)
            report_mismatch("remaining_after", out_remaining_after, want.remain);
        end
      end
    end
    pending <= expected_placements.size();
  end

endmodule

// ===== tb/sv/fit_policy_block_allocator_core_tb.sv =====
// Top of the fit-policy block allocator testbench: clock, reset, request and register
// stimulus, result-side back-pressure and the verdict. Depends on fpba_pkg, the two
// channel interfaces, the allocator core and fit_policy_block_allocator_core_checker.
module fit_policy_block_allocator_core_tb;
  import fpba_pkg::*;

  localparam int ITEM_TARGET = 650;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int items_sent;
  int hold_requests;
  int holds_done;
  bit steady_src;
  bit steady_sink;

  fpba_in_if  in_req ();
  fpba_out_if out_res ();

  fit_policy_block_allocator_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  fit_policy_block_allocator_core_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_req.valid),
    .in_ready           (in_req.ready),
    .in_mode            (in_req.mode),
    .in_block_index     (in_req.block_index),
    .in_block_capacity  (in_req.block_capacity),
    .in_request_size    (in_req.request_size),
    .out_valid          (out_res.valid),
    .out_ready          (out_res.ready),
    .out_granted        (out_res.granted),
    .out_chosen_block   (out_res.chosen_block),
    .out_remaining_after(out_res.remaining_after),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sizes that sit on boundaries and make ties likely
  function automatic logic [CAP_W-1:0] landmark_size();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'd100;
      3: return 16'h00FF;
      4: return 16'h0100;
      5: return 16'd1000;
      6: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] draw_capacity();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return landmark_size();
    if (r < 8) return CAP_W'($urandom_range(0, 2000));
    return CAP_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CAP_W-1:0] draw_request();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return landmark_size();
    if (r < 8) return CAP_W'($urandom_range(0, 600));
    if (r < 9) return '0;
    return CAP_W'($urandom_range(0, 65535));
  endfunction

  // Offer one request and wait until it is taken; valid stays up for back-to-back requests
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_FIELD_W-1:0] idx,
                           input logic [CAP_W-1:0] cap, input logic [CAP_W-1:0] req);
    int gap;
    gap = steady_src ? 0 : draw_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.mode           <= mode;
    in_req.block_index    <= idx;
    in_req.block_capacity <= cap;
    in_req.request_size   <= req;
    do @(posedge clk); while (!in_req.ready);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_load(input int span);
    logic [IDX_FIELD_W-1:0] idx;
    if (span > 0 && $urandom_range(0, 4) != 0)
      idx = IDX_FIELD_W'($urandom_range(0, span - 1));
    else
      idx = IDX_FIELD_W'($urandom_range(0, 15));
    send_item(MODE_LOAD, idx, draw_capacity(), CAP_W'($urandom_range(0, 65535)));
  endtask

  // One random phase: new register settings, refill the blocks in use, then mixed traffic
  task automatic run_phase(input int phase_no);
    logic [POLICY_W-1:0] pol;
    logic [NUMBLK_W-1:0] nblk;
    int r;
    int span;
    int count;
    pol = ($urandom_range(0, 9) == 0) ? POLICY_W'($urandom_range(5, 7))
                                      : POLICY_W'($urandom_range(0, 4));
    r = $urandom_range(0, 19);
    if (r == 0)      nblk = '0;
    else if (r < 3)  nblk = NUMBLK_W'($urandom_range(17, 31));
    else if (r < 6)  nblk = 5'd16;
    else             nblk = NUMBLK_W'($urandom_range(1, 15));
    write_reg(CFG_POLICY, {2'($urandom_range(0, 3)), pol});
    write_reg(CFG_NUM_BLOCKS, nblk);
    span = (nblk > 16) ? 16 : int'(nblk);
    steady_src  = ($urandom_range(0, 4) == 0);
    steady_sink = ($urandom_range(0, 4) == 0);

    for (int b = 0; b < span; b++)
      send_item(MODE_LOAD, IDX_FIELD_W'(b), draw_capacity(), CAP_W'($urandom_range(0, 65535)));

    count = $urandom_range(10, 30);
    for (int k = 0; k < count; k++) begin
      // long result-side hold while requests keep coming
      if (k == count / 2 && (phase_no == 2 || phase_no == 9)) begin
        steady_src = 1'b1;
        hold_requests++;
      end
      // sender stops mid-phase until everything has come back
      if (k == count / 2 && (phase_no == 4 || phase_no == 12))
        settle();
      if ($urandom_range(0, 3) == 0)
        send_load(span);
      else
        send_item(MODE_ALLOC, IDX_FIELD_W'($urandom_range(0, 15)),
                  CAP_W'($urandom_range(0, 65535)), draw_request());
    end
    settle();
  endtask

  // Result side: random stalls, steady stretches and requested long holds
  initial begin
    int stall_left;
    int g;
    stall_left    = 0;
    holds_done    = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        stall_left = LONG_HOLD - 1;
        out_res.ready <= 1'b0;
      end else if (steady_sink) begin
        out_res.ready <= 1'b1;
      end else begin
        g = draw_gap();
        if (g > 0) begin
          stall_left = g - 1;
          out_res.ready <= 1'b0;
        end else begin
          out_res.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #4000000;
    $display("fit_policy_block_allocator_core_tb: FAIL");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int phase_no;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_addr              = '0;
    cfg_wdata             = '0;
    in_req.valid          = 1'b0;
    in_req.mode           = '0;
    in_req.block_index    = '0;
    in_req.block_capacity = '0;
    in_req.request_size   = '0;
    items_sent            = 0;
    hold_requests         = 0;
    steady_src            = 1'b0;
    steady_sink           = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset: zero request fits the empty block 0, anything else fails
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'h0000);
    send_item(MODE_ALLOC, 4'hF, 16'hFFFF, 16'h0001);
    send_item(MODE_LOAD, 4'h0, 16'hFFFF, 16'h0000);
    send_item(MODE_LOAD, 4'hF, 16'hFFFF, 16'hFFFF);
    send_item(MODE_LOAD, 4'h5, 16'd100, 16'h0000);
    send_item(MODE_LOAD, 4'h9, 16'd100, 16'h0000);
    send_item(MODE_LOAD, 4'hC, 16'd50, 16'h0000);
    // first fit, exact fit to zero
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFF);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'd60);
    settle();
    write_reg(CFG_POLICY, {2'b00, POL_BEST});
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'd50);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'd40);
    send_item(MODE_LOAD, 4'h3, 16'd100, 16'h0000);
    // last fit: tie between blocks 3 and 9 goes to the higher index
    settle();
    write_reg(CFG_POLICY, {2'b00, POL_LAST});
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'd10);
    // worst fit: tie between two full blocks goes to the lower index
    settle();
    write_reg(CFG_POLICY, {2'b00, POL_WORST});
    send_item(MODE_LOAD, 4'h7, 16'hFFFF, 16'h0000);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'h0001);
    // next fit: rover advances, then runs off the end and everything fails
    settle();
    write_reg(CFG_POLICY, {2'b00, POL_NEXT});
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'h0001);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFF);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'h0000);
    // unused policy code with upper data bits set acts as first fit
    settle();
    write_reg(CFG_POLICY, 5'b11111);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'h0001);
    // no blocks in use: every request fails
    settle();
    write_reg(CFG_NUM_BLOCKS, 5'd0);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'h0000);
    // oversized block count saturates
    settle();
    write_reg(CFG_NUM_BLOCKS, 5'd31);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFE);
    settle();
    write_reg(CFG_NUM_BLOCKS, 5'd1);
    send_item(MODE_ALLOC, 4'h0, 16'h0000, 16'h0000);
    settle();

    // Random phases
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase_no);
      phase_no++;
    end

    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("fit_policy_block_allocator_core_tb: PASS");
    else
      $display("fit_policy_block_allocator_core_tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fpba_pkg.sv
rtl/core/fpba_in_if.sv
rtl/core/fpba_out_if.sv
rtl/core/fpba_table.sv
rtl/core/fit_policy_block_allocator_core.sv
tb/sv/fit_policy_block_allocator_core_checker.sv
tb/sv/fit_policy_block_allocator_core_tb.sv
